/* src/rtfx_pkg.sv */
package rtfx_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_WORD_DEF    = 16;

  // Longest keyword the decoder knows, in letters.
  localparam int KW_BYTES = 10;
  localparam int KW_W     = KW_BYTES * 8;

  localparam int OQ_DEPTH = 4;

  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_WORD = 3'd4;
  localparam logic [2:0] PH_NUM  = 3'd5;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_MAIN   = 2'd1;
  localparam logic [1:0] MODE_IGNORE = 2'd2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_NO_RTF   = 4'd1;
  localparam logic [3:0] ERR_NO_VER   = 4'd2;
  localparam logic [3:0] ERR_BAD_VER  = 4'd3;
  localparam logic [3:0] ERR_CHARSET  = 4'd4;
  localparam logic [3:0] ERR_BAD_NUM  = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX  = 4'd6;
  localparam logic [3:0] ERR_BRACE    = 4'd7;
  localparam logic [3:0] ERR_OVERFLOW = 4'd8;

  typedef struct packed {
    logic       cp;
    logic       skip;
    logic [1:0] mode;
  } rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_point;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     item;
  } res_push_t;

  function automatic logic [15:0] cp1252_low(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:  v = 16'h20AC;  5'd1:  v = 16'h0020;  5'd2:  v = 16'h201A;
      5'd3:  v = 16'h0192;  5'd4:  v = 16'h201E;  5'd5:  v = 16'h2026;
      5'd6:  v = 16'h2020;  5'd7:  v = 16'h2021;  5'd8:  v = 16'h02C6;
      5'd9:  v = 16'h2030;  5'd10: v = 16'h0160;  5'd11: v = 16'h2039;
      5'd12: v = 16'h0152;  5'd13: v = 16'h0020;  5'd14: v = 16'h017D;
      5'd15: v = 16'h0020;  5'd16: v = 16'h0020;  5'd17: v = 16'h2018;
      5'd18: v = 16'h2019;  5'd19: v = 16'h201C;  5'd20: v = 16'h201D;
      5'd21: v = 16'h2022;  5'd22: v = 16'h2013;  5'd23: v = 16'h2014;
      5'd24: v = 16'h02DC;  5'd25: v = 16'h2122;  5'd26: v = 16'h0161;
      5'd27: v = 16'h203A;  5'd28: v = 16'h0153;  5'd29: v = 16'h0020;
      5'd30: v = 16'h017E;  5'd31: v = 16'h0178;
      default: v = 16'h0020;
    endcase
    return v;
  endfunction

endpackage

/* src/rtfx_in_if.sv */
interface rtfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source(output valid, output data_byte, output end_of_input, input ready);
  modport sink(input valid, input data_byte, input end_of_input, output ready);
endinterface

/* src/rtfx_out_if.sv */
interface rtfx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] code_point;
  logic [3:0]  error_code;
  logic        last;

  modport source(output valid, output kind, output code_point, output error_code,
                 output last, input ready);
  modport sink(input valid, input kind, input code_point, input error_code,
               input last, output ready);
endinterface

/* src/rtfx_core.sv */
module rtfx_core #(
  parameter int STACK_DEPTH      = rtfx_pkg::STACK_DEPTH_DEF,
  parameter int MAX_WORD_LETTERS = rtfx_pkg::MAX_WORD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output rtfx_pkg::res_push_t push
);
  import rtfx_pkg::*;

  localparam int TW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(MAX_WORD_LETTERS + 2);

  logic [2:0]      ph_r, ph_nxt;
  logic [KW_W-1:0] word_r, word_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [31:0]     nval_r, nval_nxt;
  logic [2:0]      nflg_r, nflg_nxt;
  logic [3:0]      hexn_r, hexn_nxt;
  rec_t            rec_r, rec_nxt;
  logic [TW-1:0]   top_r, top_nxt;
  logic            err_r, err_nxt;
  logic [3:0]      errh_r, errh_nxt;
  rec_t            below_r;
  rec_t            stk_mem [STACK_DEPTH];
  logic            acc;
  logic            do_push, do_pop;
  logic [TW-1:0]   raddr;
  res_push_t       p;

  assign acc = in_valid & in_ready;

  function automatic logic kw(input logic [KW_W-1:0] w, input logic [LW-1:0] len,
                              input logic [KW_W-1:0] k, input int n);
    logic [KW_W-1:0] m;
    for (int i = 0; i < KW_BYTES; i++) begin
      m[8*i +: 8] = (i < n) ? 8'hFF : 8'h00;
    end
    return (len == LW'(n)) && (((w ^ k) & m) == '0);
  endfunction

  function automatic res_push_t add(input res_push_t q, input logic [1:0] k,
                                    input logic [15:0] c, input logic [3:0] e);
    res_push_t r;
    r = q;
    if (r.cnt != 2'd3) begin
      r.item[r.cnt] = '{kind: k, code_point: c, error_code: e, last: 1'b0};
      r.cnt = r.cnt + 2'd1;
    end
    return r;
  endfunction

  // Text goes out unless the group skips it; high bytes follow the code page bit.
  function automatic res_push_t txt(input res_push_t q, input rec_t r,
                                    input logic [15:0] v, input logic raw);
    logic [15:0] c;
    if (raw || v[7:0] < 8'h80) c = v;
    else if (!r.cp) c = 16'h0020;
    else if (v[7:0] >= 8'hA0) c = v;
    else c = cp1252_low(v[4:0]);
    return r.skip ? q : add(q, KIND_CHAR, c, ERR_NONE);
  endfunction

  function automatic void do_fail(inout logic el, inout logic [3:0] eh, inout logic se,
                                  inout res_push_t q, input logic [3:0] code);
    if (!se && !el) begin
      el = 1'b1;
      eh = code;
      se = 1'b1;
      q  = add(q, KIND_ERR, 16'h0000, code);
    end
  endfunction

  function automatic void exec_word(inout rec_t r, inout res_push_t q, inout logic el,
                                    inout logic [3:0] eh, inout logic se,
                                    input logic [KW_W-1:0] w, input logic [LW-1:0] len,
                                    input logic [2:0] nf, input logic [31:0] nv);
    logic digits;
    logic pos;
    digits = nf[1];
    pos    = nf[1] && !nf[0];
    if (r.mode == MODE_START) begin
      if (!kw(w, len, KW_W'("rtf"), 3)) do_fail(el, eh, se, q, ERR_NO_RTF);
      else if (!digits) do_fail(el, eh, se, q, ERR_NO_VER);
      else if (!(pos && nv == 32'd1)) do_fail(el, eh, se, q, ERR_BAD_VER);
      else r.mode = MODE_MAIN;
    end else if (r.mode == MODE_MAIN) begin
      if (kw(w, len, KW_W'("mac"), 3) || kw(w, len, KW_W'("pc"), 2) ||
          kw(w, len, KW_W'("pca"), 3)) begin
        do_fail(el, eh, se, q, ERR_CHARSET);
      end else if (kw(w, len, KW_W'("ansicpg"), 7)) begin
        if (pos && nv == 32'd1252) r.cp = 1'b1;
      end else if (kw(w, len, KW_W'("fonttbl"), 7) || kw(w, len, KW_W'("colortbl"), 8) ||
                   kw(w, len, KW_W'("stylesheet"), 10) || kw(w, len, KW_W'("info"), 4)) begin
        r.mode = MODE_IGNORE;
        r.skip = 1'b1;
      end else if (kw(w, len, KW_W'("bullet"), 6)) begin
        q = txt(q, r, 16'h2022, 1'b1);
      end else if (kw(w, len, KW_W'("ldblquote"), 9)) begin
        q = txt(q, r, 16'h201C, 1'b1);
      end else if (kw(w, len, KW_W'("rdblquote"), 9)) begin
        q = txt(q, r, 16'h201D, 1'b1);
      end else if (kw(w, len, KW_W'("lquote"), 6)) begin
        q = txt(q, r, 16'h2018, 1'b1);
      end else if (kw(w, len, KW_W'("rquote"), 6)) begin
        q = txt(q, r, 16'h2019, 1'b1);
      end else if (kw(w, len, KW_W'("par"), 3)) begin
        q = txt(q, r, 16'h000A, 1'b1);
        q = txt(q, r, 16'h000A, 1'b1);
      end else if (kw(w, len, KW_W'("line"), 4)) begin
        q = txt(q, r, 16'h000A, 1'b1);
      end
    end
  endfunction

  function automatic void text_byte(inout logic [2:0] ph, inout rec_t r, inout res_push_t q,
                                    inout logic el, inout logic [3:0] eh, inout logic se,
                                    inout logic pu, inout logic po,
                                    input logic [7:0] b, input logic [TW-1:0] top,
                                    input rec_t below);
    if (b == "\\") begin
      ph = PH_ESC;
    end else if (b == "{") begin
      if (({1'b0, top} + (TW+1)'(1)) >= (TW+1)'(STACK_DEPTH)) begin
        do_fail(el, eh, se, q, ERR_OVERFLOW);
      end else begin
        pu = 1'b1;
      end
    end else if (b == "}") begin
      if (top == '0) begin
        do_fail(el, eh, se, q, ERR_BRACE);
      end else begin
        po = 1'b1;
        r  = below;
      end
    end else if (b != 8'h0D && b != 8'h0A) begin
      q = txt(q, r, {8'h00, b}, 1'b0);
    end
  endfunction

  function automatic void add_digit(inout logic [31:0] nv, inout logic [2:0] nf,
                                    input logic [7:0] b);
    logic [35:0] v;
    logic [35:0] lim;
    v   = ({4'b0, nv} << 3) + ({4'b0, nv} << 1) + {32'b0, b[3:0]};
    lim = nf[0] ? 36'h080000000 : 36'h07FFFFFFF;
    nf[1] = 1'b1;
    if (!nf[2]) begin
      if (v > lim) nf[2] = 1'b1;
      else nv = v[31:0];
    end
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] h;
    if (b >= "0" && b <= "9") h = {1'b1, b[3:0]};
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) h = {1'b1, b[3:0] + 4'd9};
    else h = 5'b0;
    return h;
  endfunction

  always_comb begin
    logic       se;
    logic       letter, digit;
    logic [4:0] h;
    ph_nxt   = ph_r;
    word_nxt = word_r;
    len_nxt  = len_r;
    nval_nxt = nval_r;
    nflg_nxt = nflg_r;
    hexn_nxt = hexn_r;
    rec_nxt  = rec_r;
    top_nxt  = top_r;
    err_nxt  = err_r;
    errh_nxt = errh_r;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    se       = 1'b0;
    p        = '0;
    letter   = (data_byte >= "a" && data_byte <= "z") || (data_byte >= "A" && data_byte <= "Z");
    digit    = data_byte >= "0" && data_byte <= "9";
    h        = hex_val(data_byte);
    if (acc && end_of_input) begin
      if (!err_r) begin
        if (ph_r == PH_WORD || ph_r == PH_NUM) begin
          if (nflg_r != 3'd0 && (!nflg_r[1] || nflg_r[2]))
            do_fail(err_nxt, errh_nxt, se, p, ERR_BAD_NUM);
          else
            exec_word(rec_nxt, p, err_nxt, errh_nxt, se, word_r, len_r, nflg_r, nval_r);
        end else if (ph_r == PH_HEX2) begin
          do_fail(err_nxt, errh_nxt, se, p, ERR_BAD_HEX);
        end
      end
      p = add(p, KIND_DONE, 16'h0000, err_nxt ? errh_nxt : ERR_NONE);
      ph_nxt   = PH_TEXT;
      len_nxt  = '0;
      nval_nxt = '0;
      nflg_nxt = '0;
      hexn_nxt = '0;
      rec_nxt  = '0;
      top_nxt  = '0;
      err_nxt  = 1'b0;
      errh_nxt = ERR_NONE;
    end else if (acc && !err_r) begin
      unique case (ph_r)
        PH_ESC: begin
          ph_nxt   = PH_TEXT;
          len_nxt  = '0;
          nflg_nxt = '0;
          nval_nxt = '0;
          if (data_byte == "*") begin
            rec_nxt.skip = 1'b1;
          end else if (data_byte == 8'h27) begin
            ph_nxt = PH_HEX1;
          end else if (data_byte == "\\" || data_byte == "{" || data_byte == "}") begin
            p = txt(p, rec_nxt, {8'h00, data_byte}, 1'b1);
          end else if (letter) begin
            word_nxt = {word_r[KW_W-9:0], data_byte};
            len_nxt  = LW'(1);
            ph_nxt   = PH_WORD;
          end else if (digit || data_byte == "-") begin
            ph_nxt = PH_NUM;
            if (data_byte == "-") nflg_nxt = 3'b001;
            else add_digit(nval_nxt, nflg_nxt, data_byte);
          end else begin
            exec_word(rec_nxt, p, err_nxt, errh_nxt, se, word_r, len_nxt, nflg_nxt, nval_nxt);
            if (!se && data_byte != " ")
              text_byte(ph_nxt, rec_nxt, p, err_nxt, errh_nxt, se, do_push, do_pop,
                        data_byte, top_r, below_r);
          end
        end
        PH_HEX1: begin
          if (!h[4]) begin
            ph_nxt = PH_TEXT;
            do_fail(err_nxt, errh_nxt, se, p, ERR_BAD_HEX);
          end else begin
            hexn_nxt = h[3:0];
            ph_nxt   = PH_HEX2;
          end
        end
        PH_HEX2: begin
          ph_nxt = PH_TEXT;
          if (!h[4]) do_fail(err_nxt, errh_nxt, se, p, ERR_BAD_HEX);
          else p = txt(p, rec_nxt, {8'h00, hexn_r, h[3:0]}, 1'b0);
        end
        PH_WORD, PH_NUM: begin
          if (ph_r == PH_WORD && letter) begin
            word_nxt = {word_r[KW_W-9:0], data_byte};
            if (len_r <= LW'(MAX_WORD_LETTERS)) len_nxt = len_r + LW'(1);
          end else if (ph_r == PH_WORD && (digit || data_byte == "-")) begin
            ph_nxt   = PH_NUM;
            nval_nxt = '0;
            nflg_nxt = '0;
            if (data_byte == "-") nflg_nxt = 3'b001;
            else add_digit(nval_nxt, nflg_nxt, data_byte);
          end else if (ph_r == PH_NUM && digit) begin
            add_digit(nval_nxt, nflg_nxt, data_byte);
          end else begin
            ph_nxt = PH_TEXT;
            if (nflg_r != 3'd0 && (!nflg_r[1] || nflg_r[2]))
              do_fail(err_nxt, errh_nxt, se, p, ERR_BAD_NUM);
            else
              exec_word(rec_nxt, p, err_nxt, errh_nxt, se, word_r, len_r, nflg_r, nval_r);
            if (!se && data_byte != " ")
              text_byte(ph_nxt, rec_nxt, p, err_nxt, errh_nxt, se, do_push, do_pop,
                        data_byte, top_r, below_r);
          end
        end
        default: begin
          ph_nxt = PH_TEXT;
          text_byte(ph_nxt, rec_nxt, p, err_nxt, errh_nxt, se, do_push, do_pop,
                    data_byte, top_r, below_r);
        end
      endcase
      if (do_push) top_nxt = top_r + TW'(1);
      if (do_pop)  top_nxt = top_r - TW'(1);
    end
    if (p.cnt != 2'd0) p.item[p.cnt - 2'd1].last = 1'b1;
  end

  assign push = p;

  // Record below the top is kept in a register so that a pop needs no read delay.
  assign raddr = (top_nxt == '0) ? '0 : top_nxt - TW'(1);

  always_ff @(posedge clk) begin
    if (do_push) stk_mem[top_r] <= rec_nxt;
    if (do_push && top_r == raddr) below_r <= rec_nxt;
    else below_r <= stk_mem[raddr];
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      ph_r   <= PH_TEXT;
      len_r  <= '0;
      nval_r <= '0;
      nflg_r <= '0;
      hexn_r <= '0;
      rec_r  <= '0;
      top_r  <= '0;
      err_r  <= 1'b0;
      errh_r <= ERR_NONE;
    end else begin
      ph_r   <= ph_nxt;
      len_r  <= len_nxt;
      nval_r <= nval_nxt;
      nflg_r <= nflg_nxt;
      hexn_r <= hexn_nxt;
      rec_r  <= rec_nxt;
      top_r  <= top_nxt;
      err_r  <= err_nxt;
      errh_r <= errh_nxt;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(acc && end_of_input) |=> err_r && errh_r == $past(errh_r))
    else $error("latched error changed without end of document");

  a_pop_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> top_r != '0)
    else $error("group popped at root");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && end_of_input |=> !err_r && top_r == '0 && ph_r == PH_TEXT)
    else $error("end of document did not clear parser");

endmodule

/* src/rtfx_outq.sv */
module rtfx_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  rtfx_pkg::res_push_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output rtfx_pkg::res_t      out_item
);
  import rtfx_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  res_t          q_mem [OQ_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  // Room for the largest burst one byte can cause.
  assign space_ok  = cnt_r <= CW'(OQ_DEPTH - 3);
  assign out_valid = cnt_r != '0;
  assign out_item  = q_mem[rptr_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.cnt) q_mem[wptr_r + PW'(i)] <= push.item[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + PW'(push.cnt);
      rptr_r <= rptr_r + PW'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> space_ok)
    else $error("results pushed without room");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd0 && !pop |=> cnt_r == $past(cnt_r))
    else $error("queue count moved without traffic");

endmodule

/* src/rtf_text_extractor_top.sv */
// Channel   Dir  Payload                                     Transaction
// in_ch     in   data_byte[8], end_of_input                  one document byte or end mark
// out_ch    out  kind[2], code_point[16], error_code[4], last one result
//
// One input byte is taken per cycle while in_ch is ready; the whole token, keyword
// and stack step is done in the cycle the byte is accepted, and its 0 to 3 results
// go to a 4-entry queue. The queue drains one result per cycle while out_ch is ready,
// so a byte with several results can hold in_ch ready low until three entries are free.
// Reset is synchronous, active low, and needs no clearing pass.
// out_ch stalls only fill the queue; in_ch is ready while three entries are free.
module rtf_text_extractor_top #(
  parameter int STACK_DEPTH      = rtfx_pkg::STACK_DEPTH_DEF,
  parameter int MAX_WORD_LETTERS = rtfx_pkg::MAX_WORD_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rtfx_in_if.sink     in_ch,
  rtfx_out_if.source  out_ch
);
  import rtfx_pkg::*;

  res_push_t push;
  res_t      item;
  logic      space_ok;

  assign in_ch.ready = space_ok;

  rtfx_core #(
    .STACK_DEPTH     (STACK_DEPTH),
    .MAX_WORD_LETTERS(MAX_WORD_LETTERS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (space_ok),
    .data_byte   (in_ch.data_byte),
    .end_of_input(in_ch.end_of_input),
    .push        (push)
  );

  rtfx_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_item (item)
  );

  assign out_ch.kind       = item.kind;
  assign out_ch.code_point = item.code_point;
  assign out_ch.error_code = item.error_code;
  assign out_ch.last       = item.last;

endmodule

/* tb/rtfx_tb_if.sv */
`timescale 1ns / 100ps

// Testbench copies of the channel interfaces are not needed: the RTL provides them.
// This file holds the shared testbench types.
package rtfx_tb_pkg;
  import rtfx_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] code_point;
    logic [3:0]  error_code;
    logic        last;
  } exp_res_t;
endpackage

/* tb/rtfx_checker.sv */
`timescale 1ns / 100ps

module rtfx_checker
  import rtfx_pkg::*;
  import rtfx_tb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rtfx_in_if   in_ch,
  rtfx_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   chars_seen,
  output int   docs_seen,
  output int   errs_seen
);

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int MAXW  = MAX_WORD_DEF;

  exp_res_t   expected_q[$];

  logic [2:0] phase;
  logic [7:0] letters[MAXW];
  int         wlen;
  logic [31:0] num_val;
  logic       nf_sign, nf_digits, nf_ovf;
  logic [3:0] hex_hi;
  rec_t       recs[DEPTH];
  int         top;
  logic       err_on;
  logic [3:0] err_code;
  logic       step_err;
  exp_res_t   step_q[$];

  function automatic logic [15:0] cp_low(input logic [4:0] i);
    logic [15:0] t[32];
    t = '{16'h20AC, 16'h0020, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
          16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0020, 16'h017D, 16'h0020,
          16'h0020, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
          16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0020, 16'h017E, 16'h0178};
    return t[i];
  endfunction

  task automatic push_res(input logic [1:0] k, input logic [15:0] c, input logic [3:0] e);
    exp_res_t r;
    if (step_q.size() >= 3) return;
    r.kind = k; r.code_point = c; r.error_code = e; r.last = 1'b0;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic raise(input logic [3:0] e);
    if (step_err || err_on) return;
    err_on = 1'b1; err_code = e; step_err = 1'b1;
    push_res(KIND_ERR, 16'h0, e);
  endtask

  task automatic clear_parser();
    phase = PH_TEXT;
    wlen = 0; num_val = '0;
    nf_sign = 0; nf_digits = 0; nf_ovf = 0;
    hex_hi = '0;
    foreach (recs[i]) recs[i] = '0;
    top = 0; err_on = 0; err_code = ERR_NONE;
  endtask

  task automatic put_char(input logic [15:0] b, input bit raw);
    rec_t r;
    r = recs[top];
    if (r.skip) return;
    if (raw || b < 16'h80) push_res(KIND_CHAR, b, ERR_NONE);
    else if (!r.cp) push_res(KIND_CHAR, 16'h20, ERR_NONE);
    else if (b >= 16'hA0) push_res(KIND_CHAR, b, ERR_NONE);
    else push_res(KIND_CHAR, cp_low(b[4:0]), ERR_NONE);
  endtask

  function automatic bit word_eq(input string s);
    if (wlen != s.len() || wlen > MAXW) return 0;
    for (int i = 0; i < wlen; i++) if (letters[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic bit param_eq(input logic [31:0] v);
    return nf_digits && !nf_sign && num_val == v;
  endfunction

  task automatic run_word();
    rec_t r;
    r = recs[top];
    if (r.mode == MODE_START) begin
      if (!word_eq("rtf")) raise(ERR_NO_RTF);
      else if (!nf_digits) raise(ERR_NO_VER);
      else if (!param_eq(1)) raise(ERR_BAD_VER);
      else recs[top].mode = MODE_MAIN;
      return;
    end
    if (r.mode != MODE_MAIN) return;
    if (word_eq("mac") || word_eq("pc") || word_eq("pca")) raise(ERR_CHARSET);
    else if (word_eq("ansicpg")) begin
      if (param_eq(1252)) recs[top].cp = 1'b1;
    end else if (word_eq("fonttbl") || word_eq("colortbl") || word_eq("stylesheet") ||
                 word_eq("info")) begin
      recs[top].mode = MODE_IGNORE;
      recs[top].skip = 1'b1;
    end else if (word_eq("bullet")) put_char(16'h2022, 1);
    else if (word_eq("ldblquote")) put_char(16'h201C, 1);
    else if (word_eq("rdblquote")) put_char(16'h201D, 1);
    else if (word_eq("lquote")) put_char(16'h2018, 1);
    else if (word_eq("rquote")) put_char(16'h2019, 1);
    else if (word_eq("par")) begin
      put_char(16'h0A, 1); put_char(16'h0A, 1);
    end else if (word_eq("line")) put_char(16'h0A, 1);
  endtask

  task automatic end_token();
    phase = PH_TEXT;
    if ((nf_sign || nf_digits || nf_ovf) && (!nf_digits || nf_ovf)) begin
      raise(ERR_BAD_NUM);
      return;
    end
    run_word();
  endtask

  task automatic plain_byte(input logic [7:0] b);
    if (b == "\\") phase = PH_ESC;
    else if (b == "{") begin
      if (top + 1 >= DEPTH) raise(ERR_OVERFLOW);
      else begin
        recs[top + 1] = recs[top];
        top++;
      end
    end else if (b == "}") begin
      if (top == 0) raise(ERR_BRACE);
      else top--;
    end else if (b == 8'h0D || b == 8'h0A) begin
    end else put_char({8'h0, b}, 0);
  endtask

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int hex_of(input logic [7:0] b);
    if (is_num(b)) return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic add_letter(input logic [7:0] b);
    if (wlen < MAXW) letters[wlen] = b;
    if (wlen <= MAXW) wlen++;
  endtask

  task automatic add_digit(input logic [7:0] b);
    logic [63:0] lim, v;
    lim = nf_sign ? 64'd2147483648 : 64'd2147483647;
    v = {32'h0, num_val} * 10 + (b - "0");
    nf_digits = 1;
    if (nf_ovf) return;
    if (v > lim) nf_ovf = 1;
    else num_val = v[31:0];
  endtask

  task automatic begin_number(input logic [7:0] b);
    num_val = '0; nf_sign = 0; nf_digits = 0; nf_ovf = 0;
    phase = PH_NUM;
    if (b == "-") nf_sign = 1;
    else add_digit(b);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int h;
    case (phase)
      PH_ESC: begin
        phase = PH_TEXT;
        wlen = 0; nf_sign = 0; nf_digits = 0; nf_ovf = 0; num_val = '0;
        if (b == "*") recs[top].skip = 1'b1;
        else if (b == "'") phase = PH_HEX1;
        else if (b == "\\" || b == "{" || b == "}") put_char({8'h0, b}, 1);
        else if (is_alpha(b)) begin
          add_letter(b);
          phase = PH_WORD;
        end else if (is_num(b) || b == "-") begin_number(b);
        else if (b == " ") run_word();
        else begin
          run_word();
          if (!step_err) plain_byte(b);
        end
      end
      PH_HEX1: begin
        h = hex_of(b);
        if (h < 0) begin
          phase = PH_TEXT;
          raise(ERR_BAD_HEX);
        end else begin
          hex_hi = h[3:0];
          phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        h = hex_of(b);
        phase = PH_TEXT;
        if (h < 0) raise(ERR_BAD_HEX);
        else put_char({8'h0, hex_hi, h[3:0]}, 0);
      end
      PH_WORD: begin
        if (is_alpha(b)) add_letter(b);
        else if (is_num(b) || b == "-") begin_number(b);
        else if (b == " ") end_token();
        else begin
          end_token();
          if (!step_err) plain_byte(b);
        end
      end
      PH_NUM: begin
        if (is_num(b)) add_digit(b);
        else if (b == " ") end_token();
        else begin
          end_token();
          if (!step_err) plain_byte(b);
        end
      end
      default: begin
        phase = PH_TEXT;
        plain_byte(b);
      end
    endcase
  endtask

  task automatic predict_results(input logic [7:0] b, input logic eoi);
    step_q.delete();
    step_err = 0;
    if (eoi) begin
      if (!err_on) begin
        if (phase == PH_WORD || phase == PH_NUM) end_token();
        else if (phase == PH_HEX2) raise(ERR_BAD_HEX);
      end
      push_res(KIND_DONE, 16'h0, err_on ? err_code : ERR_NONE);
      clear_parser();
    end else if (!err_on) parse_byte(b);
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
  endtask

  initial begin
    fail_count = 0; chars_seen = 0; docs_seen = 0; errs_seen = 0;
    pending = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    exp_res_t e;
    if (rst_n) begin
      // Results are checked before the new transaction adds its own.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result kind=%0d cp=%h err=%0d", out_ch.kind,
                     out_ch.code_point, out_ch.error_code);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.kind !== e.kind || out_ch.code_point !== e.code_point ||
              out_ch.error_code !== e.error_code || out_ch.last !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp kind=%0d cp=%h err=%0d last=%0d, got %0d %h %0d %0d",
                       e.kind, e.code_point, e.error_code, e.last, out_ch.kind,
                       out_ch.code_point, out_ch.error_code, out_ch.last);
          end
          case (out_ch.kind)
            KIND_CHAR: chars_seen++;
            KIND_DONE: docs_seen++;
            default:   errs_seen++;
          endcase
        end
      end
      if (in_ch.valid && in_ch.ready) predict_results(in_ch.data_byte, in_ch.end_of_input);
    end
    pending = expected_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import rtfx_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, chars_seen, docs_seen, errs_seen;
  int   send_idle_pct, recv_stall_pct;

  rtfx_in_if  in_ch();
  rtfx_out_if out_ch();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rtf_text_extractor_top u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rtfx_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .pending(pending), .chars_seen(chars_seen), .docs_seen(docs_seen), .errs_seen(errs_seen)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
  end

  // The receiver stalls independently of the sender.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  byte unsigned doc_q[$];
  bit           doc_end_q[$];
  int           items_sent;

  task automatic send_byte(input logic [7:0] b, input bit eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      doc_q.insert(doc_q.size(), s[i]);
      doc_end_q.insert(doc_end_q.size(), 1'b0);
    end
  endtask

  task automatic add_end();
    doc_q.insert(doc_q.size(), 8'($urandom_range(255)));
    doc_end_q.insert(doc_end_q.size(), 1'b1);
  endtask

  // The last transaction stays on the bus until a later send or the end of the run drops it.
  task automatic flush_doc();
    while (doc_q.size() > 0) send_byte(doc_q.pop_front(), doc_end_q.pop_front());
  endtask

  function automatic string pick_piece();
    string parts[24];
    parts = '{"\\par ", "\\bullet ", "\\ldblquote x", "\\rdblquote ", "\\lquote ", "\\rquote",
              "\\line ", "{\\fonttbl f;}", "{\\colortbl ;}", "{\\info t}", "{\\stylesheet s}",
              "\\ansicpg1252 ", "\\ansicpg437 ", "{\\*\\gen x}", "\\'e9", "\\'8A", "\\\\",
              "\\{", "\\}", "\\b0 ", "\\fs-24 ", "\\~", "\\abcdefghijklmnopqrs ", "\r\n"};
    return parts[$urandom_range(23)];
  endfunction

  task automatic add_random_doc();
    int n, depth;
    depth = 0;
    if ($urandom_range(9) != 0) add_text("{\\rtf1 ");
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin
          add_text("{");
          depth++;
        end
        1: if (depth > 0) begin
          add_text("}");
          depth--;
        end
        2: begin
          doc_q.insert(doc_q.size(), 8'($urandom_range(255)));
          doc_end_q.insert(doc_end_q.size(), 1'b0);
        end
        3: add_text($sformatf("%c", $urandom_range(32, 126)));
        default: add_text(pick_piece());
      endcase
    end
    if ($urandom_range(3) != 0) add_text("}");
    add_end();
  endtask

  initial begin
    int pass_no;
    string hexs;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed documents: keywords, codepage, skipped groups, and each error kind.
    // They run with neither side idling.
    add_text("{\\rtf1\\ansicpg1252 A\\'80\\'e9\x80\xff\\bullet\\par ");
    add_text("{\\info x}\\ldblquote\\rquote\\line\\{\\\\}");
    add_end();
    add_text("\\x"); add_end();
    add_text("{\\rtf "); add_end();
    add_text("{\\rtf2 "); add_end();
    add_text("{\\rtf1\\mac "); add_end();
    add_text("{\\rtf1\\fs- "); add_end();
    add_text("{\\rtf1\\fs99999999999 x"); add_end();
    add_text("{\\rtf1\\'zz"); add_end();
    add_text("{\\rtf1\\'4"); add_end();
    add_text("{\\rtf1 }}x"); add_end();
    add_text("{\\rtf1 \x80 \\~\\"); add_end();
    add_text("{\\rtf1\\f-2147483648\\f2147483647"); add_end();
    for (int i = 0; i < 33; i++) add_text("{");
    add_end();
    flush_doc();

    for (pass_no = 1; pass_no < 4; pass_no++) begin
      case (pass_no)
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      add_random_doc();
      flush_doc();
    end
    in_ch.valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("tb: %0d bytes sent; %0d characters, %0d documents, %0d errors checked",
             items_sent, chars_seen, docs_seen, errs_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule

/* rtf_text_extractor_top.f */
src/rtfx_pkg.sv
src/rtfx_in_if.sv
src/rtfx_out_if.sv
src/rtfx_core.sv
src/rtfx_outq.sv
src/rtf_text_extractor_top.sv
tb/rtfx_tb_if.sv
tb/rtfx_checker.sv
tb/tb.sv
